// File: src/fccw_pkg.sv
`timescale 1ns / 1ps
// Package for the FAT12 cluster chain walker.
// Holds the codes, table geometry and the control/status structs; no dependencies.
package fccw_pkg;

  localparam int TABLE_BYTES = 8192;
  localparam int TBL_AW      = $clog2(TABLE_BYTES);

  localparam logic [11:0] ENTRY_MASK = 12'h0FFF;
  localparam logic [11:0] END_MARK   = 12'hFF8;

  typedef enum logic [1:0] {
    FN_LOAD = 2'd0,
    FN_OPEN = 2'd1,
    FN_ADV  = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_END   = 2'd1,
    ST_LOAD  = 2'd2
  } status_t;

  // Source of the sector address that the final stage puts out.
  typedef enum logic [1:0] {
    LK_ZERO = 2'd0,
    LK_ROOT = 2'd1,
    LK_CLUS = 2'd2
  } lba_kind_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_MUL  = 2'd2,
    S_DONE = 2'd3
  } state_t;

  localparam logic REG_DATA_START = 1'b0;
  localparam logic REG_SPC        = 1'b1;

  typedef struct packed {
    logic accept;
    logic exec;
    logic mul;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// File: src/fccw_regs.sv
`timescale 1ns / 1ps
// Configuration registers of the chain walker behind an APB-style port.
// Depends on fccw_pkg.
module fccw_regs
  import fccw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] data_start_lba,
  output logic [7:0]  clus_size
);

  logic [31:0] data_start_r;
  logic [7:0]  spc_r;
  logic        wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_start_r <= '0;
      spc_r        <= 8'd1;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_DATA_START: data_start_r <= pwdata;
        REG_SPC:        spc_r        <= pwdata[7:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DATA_START: prdata = data_start_r;
      REG_SPC:        prdata = {24'd0, spc_r};
      default:        prdata = '0;
    endcase
  end

  assign data_start_lba = data_start_r;
  assign clus_size      = spc_r;

endmodule

// File: src/fccw_ctrl.sv
`timescale 1ns / 1ps
// Controller of the chain walker: sequences accept, update, multiply and output.
// Depends on fccw_pkg.
module fccw_ctrl
  import fccw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DONE;
      S_DONE: if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_EXEC: cmd.exec = 1'b1;
      S_MUL:  cmd.mul  = 1'b1;
      S_DONE: cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

endmodule

// File: src/fccw_dp.sv
`timescale 1ns / 1ps
// Datapath of the chain walker: table memory, walk state, multiply-add, output register.
// Depends on fccw_pkg.
module fccw_dp
  import fccw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  in_func,
  input  logic [12:0] in_table_index,
  input  logic [7:0]  in_table_byte,
  input  logic [11:0] in_start_cluster,
  input  logic [31:0] in_start_lba,
  input  logic        in_is_root,
  input  logic [31:0] data_start_lba,
  input  logic [7:0]  clus_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sector_lba,
  output logic [1:0]  out_status
);

  logic [7:0] mem [TABLE_BYTES];
  logic [7:0] rd0_r, rd1_r;

  func_t       func_r;
  logic [11:0] start_cluster_r;
  logic [31:0] start_lba_r;
  logic        is_root_r;

  logic [11:0] cur_cluster_r, cur_cluster_nxt;
  logic [6:0]  cur_sector_r, cur_sector_nxt;
  logic [31:0] root_lba_r, root_lba_nxt;
  logic        root_mode_r, root_mode_nxt;
  logic        chain_ended_r, chain_ended_nxt;
  status_t     res_status_r, res_status_nxt;
  lba_kind_t   res_kind_r, res_kind_nxt;

  logic signed [21:0] prod_r;
  logic               out_valid_r;
  logic [31:0]        out_lba_r;
  status_t            out_status_r;

  logic [12:0]        rd_pos;
  logic               wr_en;
  logic [7:0]         eff_spc;
  logic [15:0]        half;
  logic [11:0]        entry;
  logic [7:0]         sec_inc;
  logic [11:0]        adv_cluster;
  logic signed [12:0] cl_m2;
  logic signed [8:0]  spc_s;
  logic [31:0]        lba_sum;

  // Byte offset of the current cluster's entry: cluster * 3 / 2.
  assign rd_pos = {1'b0, cur_cluster_r} + {2'b0, cur_cluster_r[11:1]};
  assign wr_en  = cmd.accept && (func_t'(in_func) == FN_LOAD)
                  && (32'(in_table_index) < TABLE_BYTES);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[TBL_AW'(in_table_index)] <= in_table_byte;
    end
    if (cmd.accept) begin
      rd0_r <= mem[TBL_AW'(rd_pos)];
      rd1_r <= mem[TBL_AW'(rd_pos + 13'd1)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r          <= func_t'(in_func);
      start_cluster_r <= in_start_cluster;
      start_lba_r     <= in_start_lba;
      is_root_r       <= in_is_root;
    end
  end

  // Out-of-range cluster sizes saturate to the legal range of 1 to 128.
  always_comb begin
    if (clus_size == 8'd0) begin
      eff_spc = 8'd1;
    end else if (clus_size > 8'd128) begin
      eff_spc = 8'd128;
    end else begin
      eff_spc = clus_size;
    end
  end

  assign half    = {rd1_r, rd0_r};
  assign entry   = cur_cluster_r[0] ? (half[15:4] & ENTRY_MASK) : (half[11:0] & ENTRY_MASK);
  assign sec_inc = {1'b0, cur_sector_r} + 8'd1;

  always_comb begin
    cur_cluster_nxt = cur_cluster_r;
    cur_sector_nxt  = cur_sector_r;
    root_lba_nxt    = root_lba_r;
    root_mode_nxt   = root_mode_r;
    chain_ended_nxt = chain_ended_r;
    res_status_nxt  = ST_LOAD;
    res_kind_nxt    = LK_ZERO;
    adv_cluster     = cur_cluster_r;
    unique case (func_r)
      FN_OPEN: begin
        chain_ended_nxt = 1'b0;
        cur_sector_nxt  = '0;
        res_status_nxt  = ST_VALID;
        if (is_root_r) begin
          root_mode_nxt   = 1'b1;
          root_lba_nxt    = start_lba_r;
          cur_cluster_nxt = '0;
          res_kind_nxt    = LK_ROOT;
        end else begin
          root_mode_nxt   = 1'b0;
          cur_cluster_nxt = start_cluster_r;
          res_kind_nxt    = LK_CLUS;
        end
      end
      FN_ADV: begin
        if (chain_ended_r) begin
          res_status_nxt = ST_END;
        end else if (root_mode_r) begin
          root_lba_nxt   = root_lba_r + 32'd1;
          res_status_nxt = ST_VALID;
          res_kind_nxt   = LK_ROOT;
        end else begin
          if (sec_inc >= eff_spc) begin
            cur_sector_nxt = '0;
            adv_cluster    = entry;
          end else begin
            cur_sector_nxt = sec_inc[6:0];
          end
          cur_cluster_nxt = adv_cluster;
          if (adv_cluster >= END_MARK) begin
            chain_ended_nxt = 1'b1;
            res_status_nxt  = ST_END;
          end else begin
            res_status_nxt = ST_VALID;
            res_kind_nxt   = LK_CLUS;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_cluster_r <= '0;
      cur_sector_r  <= '0;
      root_lba_r    <= '0;
      root_mode_r   <= 1'b0;
      chain_ended_r <= 1'b0;
    end else if (cmd.exec) begin
      cur_cluster_r <= cur_cluster_nxt;
      cur_sector_r  <= cur_sector_nxt;
      root_lba_r    <= root_lba_nxt;
      root_mode_r   <= root_mode_nxt;
      chain_ended_r <= chain_ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r <= res_status_nxt;
      res_kind_r   <= res_kind_nxt;
    end
  end

  // (cluster - 2) * size is formed signed; sign extension then gives the 32-bit wrap.
  assign cl_m2 = $signed({1'b0, cur_cluster_r}) - 13'sd2;
  assign spc_s = $signed({1'b0, eff_spc});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= cl_m2 * spc_s;
    end
  end

  assign lba_sum = data_start_lba + {{10{prod_r[21]}}, prod_r} + {25'd0, cur_sector_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      case (res_kind_r)
        LK_ROOT: out_lba_r <= root_lba_r;
        LK_CLUS: out_lba_r <= lba_sum;
        default: out_lba_r <= '0;
      endcase
    end
  end

  assign sts.out_free   = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_sector_lba = out_lba_r;
  assign out_status     = out_status_r;

endmodule

// File: src/fat12_cluster_chain_walker.sv
`timescale 1ns / 1ps
// Top level of the FAT12 cluster chain walker.
// Depends on fccw_pkg, fccw_regs, fccw_ctrl and fccw_dp.
//
// The block keeps an 8192-byte FAT12 allocation table and walks cluster chains.
// Input transfers (in_valid/in_ready) carry one command each: a table byte
// load, an open of a clustered file or of the linear root directory, or an
// advance to the next sector. Every accepted command yields exactly one output
// transfer (out_valid/out_ready) carrying a sector LBA and a status code.
//
// The input transfer registers the command and reads the table through its
// synchronous port; then come the update of the walk state, the registered
// (cluster - 2) * cluster-size product and the final add into the output
// register. The block handles one command at a time; the next command is
// accepted in the cycle after the result is registered.
//
// The output register parts the two sides: a new command is taken while a
// finished result still waits. If the receiver stalls longer, the following
// result is held in the controller's final state until the register frees up.
//
// Reset (synchronous, active low) clears the walk state, the output valid and
// restores the configuration defaults. The table contents are not cleared; a
// never-loaded entry returns whatever the memory holds. The user is to write
// configuration over the APB-style port while the block is idle (not enforced).
module fat12_cluster_chain_walker
  import fccw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [12:0] in_table_index,
  input  logic [7:0]  in_table_byte,
  input  logic [11:0] in_start_cluster,
  input  logic [31:0] in_start_lba,
  input  logic        in_is_root,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sector_lba,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] data_start_lba;
  logic [7:0]  clus_size;

  // Register file: the two configuration registers live at byte offsets 0 and 4.
  fccw_regs u_regs (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .data_start_lba (data_start_lba),
    .clus_size      (clus_size)
  );

  // Controller: decides when a transfer is taken and steps the datapath.
  fccw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: table memory, walk state and the output register.
  fccw_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_func),
    .in_table_index   (in_table_index),
    .in_table_byte    (in_table_byte),
    .in_start_cluster (in_start_cluster),
    .in_start_lba     (in_start_lba),
    .in_is_root       (in_is_root),
    .data_start_lba   (data_start_lba),
    .clus_size        (clus_size),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sector_lba   (out_sector_lba),
    .out_status       (out_status)
  );

endmodule

// File: src/fccw_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the chain walker, bound to the top level.
// Depends on fccw_pkg and fat12_cluster_chain_walker.
module fccw_checker
  import fccw_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_sector_lba,
  input logic [1:0]  out_status
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sector_lba) && $stable(out_status))
    else $error("output changed while stalled");

  // Commands are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

  // Loads and end of chain carry a zero address.
  a_zero_lba: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_END || out_status == ST_LOAD) |-> out_sector_lba == '0)
    else $error("nonzero address with end or load status");

  // The unused status code never appears.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind fat12_cluster_chain_walker fccw_checker u_fccw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sector_lba (out_sector_lba),
  .out_status     (out_status)
);
